>>> design/sva_pkg.sv
// Shared types and constants for the voice allocator.
// No dependencies.
package sva_pkg;

  typedef enum logic [2:0] {
    MODE_POLY    = 3'd0,
    MODE_LAST    = 3'd1,
    MODE_FIRST   = 3'd2,
    MODE_HIGHEST = 3'd3,
    MODE_LOWEST  = 3'd4,
    MODE_LEGATO  = 3'd5
  } mode_t;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HPUSH_RD,    // full history: shift read phase
    ST_HPUSH_WR,
    ST_HERASE_RD,   // compaction read
    ST_HERASE_WR,
    ST_HPICK_RD,    // scan history for resume pick
    ST_HPICK_DO,
    ST_HPICK_FETCH,
    ST_HPICK_GOT,
    ST_VSCAN,       // voice scan, one voice per cycle while the output is free
    ST_EMIT,        // wait for output slot
    ST_PICK,        // pick voice (oldest free, else oldest playing) over cycles
    ST_START
  } state_t;

endpackage

>>> design/sva_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/synth_voice_allocator_core.sv
// Polyphonic/mono voice allocator. One event word in, up to VOICES+1 command
// words out. Voice state (active, pitch, stamp) lives in flip-flops, one entry
// per voice, scanned one voice per cycle while the output is not stalled; the
// held-note history is a RAM with registered read. Steps per event: poly
// note-on picks a voice and starts it; poly note-off scans the voices; mono
// note-on pushes the history (shifting it when full), then scans the voices,
// picks one and starts it; mono note-off erases the note from the history and
// scans the voices, and when a held note is resumed adds pick scan, fetch,
// voice pick and start. A consumer stall on a pending word holds the state.
// Depends on sva_pkg and sva_ram.
module synth_voice_allocator_core
  import sva_pkg::*;
#(
  parameter int VOICES        = 8,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_priority_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [6:0] in_note,
  input  logic [6:0] in_velocity,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_voice,
  output logic       out_start_res,
  output logic [6:0] out_pitch,
  output logic [6:0] out_strength,
  output logic       out_retrigger,
  output logic       out_last
);
  localparam int VW = $clog2(VOICES);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  // voice bank
  logic [VOICES-1:0] act_r;
  logic [6:0]        vp_r  [VOICES];
  logic [15:0]       vs_r  [VOICES];
  logic [15:0]       stamp_r;
  logic [6:0]        mono_r;
  logic [2:0]        mode_r;
  logic [CW-1:0]     cnt_r;

  state_t st_r, st_nxt;
  logic          kind_r;
  logic [6:0]    note_r, vel_r;
  logic [CW-1:0] rp_r, wp_r;          // history read / write pointers
  logic [VW:0]   vi_r;                // voice scan index
  logic          stopped_r;
  logic [HW-1:0] pk_r;                // resume pick index
  logic [6:0]    pkn_r;
  logic [VW-1:0] best_r;
  logic [15:0]   bage_r;
  logic          bfree_r;
  logic          retrig_r;
  logic [6:0]    snote_r, svel_r;     // note to start

  // output register
  logic       ov_r;
  logic [2:0] ovo_r;
  logic       ost_r, ort_r, ola_r;
  logic [6:0] op_r, os_r;

  // history RAM
  logic          h_we;
  logic [HW-1:0] h_wa, h_ra;
  logic [13:0]   h_wd, h_rd;

  sva_ram #(.WIDTH(14), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE) && !in_valid;

  assign out_valid     = ov_r;
  assign out_voice     = ovo_r;
  assign out_start_res = ost_r;
  assign out_pitch     = op_r;
  assign out_strength  = os_r;
  assign out_retrigger = ort_r;
  assign out_last      = ola_r;

  logic is_poly;
  assign is_poly = (mode_r == MODE_POLY);

  logic [VW-1:0] vi;
  assign vi = vi_r[VW-1:0];
  logic [15:0] age_cur;
  assign age_cur = stamp_r - vs_r[vi];

  logic [CW-1:0] cnt_after_push;
  assign cnt_after_push = (cnt_r >= CW'(HISTORY_DEPTH)) ? cnt_r : cnt_r + 1'b1;

  // mono note-on ignore test, on the count after the push
  logic ignore_on;
  always_comb begin
    ignore_on = 1'b0;
    if (cnt_after_push > CW'(1)) begin
      case (mode_r)
        MODE_FIRST:   ignore_on = 1'b1;
        MODE_HIGHEST: ignore_on = note_r < mono_r;
        MODE_LOWEST:  ignore_on = note_r > mono_r;
        default:      ignore_on = 1'b0;
      endcase
    end
  end

  logic resume_ok;
  assign resume_ok = (mode_r == MODE_LAST) || (mode_r == MODE_FIRST) ||
                     (mode_r == MODE_HIGHEST) || (mode_r == MODE_LOWEST);

  // voice scan action for current index
  logic scan_emit;
  always_comb begin
    if (kind_r == KIND_ON) scan_emit = 1'b1;
    else scan_emit = act_r[vi] && vp_r[vi] == note_r;
  end
  // another playing voice above the scan index holds the released note
  logic later_match;
  always_comb begin
    later_match = 1'b0;
    for (int j = 0; j < VOICES; j++)
      if (j > int'(vi_r) && act_r[j] && vp_r[j] == note_r) later_match = 1'b1;
  end
  logic scan_end_after;  // this emit ends the event
  assign scan_end_after = (kind_r == KIND_OFF) &&
    (is_poly || (!later_match && !(cnt_r != '0 && resume_ok)));

  // a command word is loaded this cycle
  logic emit_now;
  assign emit_now = out_free && ((st_r == ST_VSCAN && scan_emit) || st_r == ST_START);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) begin
        if (mode_r == MODE_POLY)
          st_nxt = (in_kind == KIND_ON) ? ST_PICK : ST_VSCAN;
        else if (in_kind == KIND_ON)
          st_nxt = (cnt_r >= CW'(HISTORY_DEPTH)) ? ST_HPUSH_RD : ST_HPUSH_WR;
        else
          st_nxt = ST_HERASE_RD;
      end
      ST_HPUSH_RD: st_nxt = ST_HPUSH_WR;
      ST_HPUSH_WR: begin
        if (rp_r != '0 && rp_r < CW'(HISTORY_DEPTH)) st_nxt = ST_HPUSH_WR;
        else st_nxt = ignore_on ? ST_IDLE : ST_VSCAN;
      end
      ST_HERASE_RD: st_nxt = (rp_r >= cnt_r) ? ST_VSCAN : ST_HERASE_WR;
      ST_HERASE_WR: st_nxt = ST_HERASE_RD;
      ST_VSCAN: begin
        if (scan_emit && !out_free) st_nxt = ST_VSCAN;
        else if (kind_r == KIND_OFF && is_poly && scan_emit) st_nxt = ST_IDLE;
        else if (vi_r == (VW+1)'(VOICES-1)) begin
          if (kind_r == KIND_ON) st_nxt = ST_PICK;
          else if (is_poly) st_nxt = ST_IDLE;
          else if ((stopped_r || scan_emit) && cnt_r != '0 && resume_ok)
            st_nxt = ST_HPICK_RD;
          else st_nxt = ST_IDLE;
        end
      end
      ST_HPICK_RD:  st_nxt = ST_HPICK_DO;
      ST_HPICK_DO:  st_nxt = (rp_r >= cnt_r) ? ST_HPICK_FETCH : ST_HPICK_DO;
      ST_HPICK_FETCH: st_nxt = ST_HPICK_GOT;
      ST_HPICK_GOT: st_nxt = ST_PICK;
      ST_PICK: st_nxt = (vi_r == (VW+1)'(VOICES-1)) ? ST_START : ST_PICK;
      ST_START: st_nxt = out_free ? ST_IDLE : ST_START;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // history port control
  always_comb begin
    h_we = 1'b0;
    h_wa = '0;
    h_wd = {note_r, vel_r};
    h_ra = rp_r[HW-1:0];
    case (st_r)
      ST_IDLE: h_ra = '0;
      ST_HPUSH_RD: h_ra = HW'(1);
      ST_HPUSH_WR: begin
        h_we = 1'b1;
        if (rp_r != '0 && rp_r < CW'(HISTORY_DEPTH)) begin
          h_wa = HW'(rp_r - 1'b1);
          h_wd = h_rd;
          h_ra = HW'(rp_r + 1'b1);
        end else begin
          h_wa = HW'(cnt_after_push - 1'b1);
        end
      end
      ST_HERASE_WR: begin
        h_we = (h_rd[13:7] != note_r);
        h_wa = wp_r[HW-1:0];
        h_wd = h_rd;
      end
      ST_HPICK_RD: h_ra = '0;
      ST_HPICK_DO: h_ra = HW'(rp_r);
      ST_HPICK_FETCH: h_ra = pk_r;
      default: ;
    endcase
  end

  logic better;
  always_comb begin
    better = (vi_r == '0) || (!act_r[vi] && !bfree_r) ||
             ((!act_r[vi]) == bfree_r && age_cur > bage_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mode_r <= MODE_POLY; cnt_r <= '0; act_r <= '0;
      stamp_r <= '0; mono_r <= '0; ov_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin vp_r[i] <= '0; vs_r[i] <= '0; end
    end else begin
      st_r <= st_nxt;
      if (emit_now) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_priority_mode != mode_r) cnt_r <= '0;
        mode_r <= cfg_priority_mode;
      end
      case (st_r)
        ST_IDLE: if (in_valid) begin
          kind_r <= in_kind; note_r <= in_note; vel_r <= in_velocity;
          vi_r <= '0; stopped_r <= 1'b0; retrig_r <= 1'b0;
          snote_r <= in_note; svel_r <= in_velocity;
          rp_r <= (mode_r != MODE_POLY && in_kind == KIND_ON &&
                   cnt_r >= CW'(HISTORY_DEPTH)) ? CW'(1) : '0;
          wp_r <= '0;
        end
        ST_HPUSH_RD: ;
        ST_HPUSH_WR: begin
          if (rp_r != '0 && rp_r < CW'(HISTORY_DEPTH)) rp_r <= rp_r + 1'b1;
          else begin
            rp_r <= '0;
            cnt_r <= cnt_after_push;
          end
        end
        ST_HERASE_RD: if (rp_r >= cnt_r) cnt_r <= wp_r;
        ST_HERASE_WR: begin
          rp_r <= rp_r + 1'b1;
          if (h_rd[13:7] != note_r) wp_r <= wp_r + 1'b1;
        end
        ST_VSCAN: begin
          if (!(scan_emit && !out_free)) begin
            if (scan_emit) begin
              ovo_r <= 3'(vi); ost_r <= 1'b0;
              op_r <= (kind_r == KIND_ON) ? vp_r[vi] : note_r;
              os_r <= '0; ort_r <= 1'b0; ola_r <= scan_end_after;
              act_r[vi] <= 1'b0; stopped_r <= 1'b1;
            end
            vi_r <= (vi_r == (VW+1)'(VOICES-1)) ? '0 : vi_r + 1'b1;
            if (kind_r == KIND_ON && vi_r == (VW+1)'(VOICES-1)) mono_r <= note_r;
          end
        end
        ST_HPICK_RD: begin rp_r <= '0; pk_r <= '0; end
        ST_HPICK_DO: begin
          // h_rd holds entry rp_r-1 once rp_r >= 1
          if (rp_r != '0) begin
            if (rp_r == CW'(1)) pkn_r <= h_rd[13:7];
            else case (mode_r)
              MODE_LAST: begin pk_r <= HW'(rp_r - 1'b1); pkn_r <= h_rd[13:7]; end
              MODE_HIGHEST: if (h_rd[13:7] > pkn_r) begin
                pk_r <= HW'(rp_r - 1'b1); pkn_r <= h_rd[13:7];
              end
              MODE_LOWEST: if (h_rd[13:7] < pkn_r) begin
                pk_r <= HW'(rp_r - 1'b1); pkn_r <= h_rd[13:7];
              end
              default: ;
            endcase
          end
          rp_r <= rp_r + 1'b1;
        end
        ST_HPICK_FETCH: ;
        ST_HPICK_GOT: begin
          snote_r <= h_rd[13:7]; svel_r <= h_rd[6:0]; mono_r <= h_rd[13:7];
          retrig_r <= 1'b1; vi_r <= '0;
        end
        ST_PICK: begin
          if (better) begin best_r <= vi; bage_r <= age_cur; bfree_r <= !act_r[vi]; end
          vi_r <= (vi_r == (VW+1)'(VOICES-1)) ? '0 : vi_r + 1'b1;
        end
        ST_START: if (out_free) begin
          ovo_r <= 3'(best_r); ost_r <= 1'b1; op_r <= snote_r;
          os_r <= svel_r; ort_r <= retrig_r; ola_r <= 1'b1;
          stamp_r <= stamp_r + 1'b1; vs_r[best_r] <= stamp_r + 1'b1;
          act_r[best_r] <= 1'b1; vp_r[best_r] <= snote_r;
        end
        default: ;
      endcase
    end
  end

  // history count never passes the depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
  // a start word always ends its event
  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r) |-> ola_r) else $error("start not last");
  // no new event while busy
  a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == ST_IDLE) else $error("ready outside idle");
endmodule
